@@ hdl/rwcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall column rasterizer package
// Widths, codes and the command and status bundles shared between the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package rwcr_pkg;

    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int RGB_W      = 24;
    localparam int FIX_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int LINE_W     = 16;
    localparam int TIDX_W     = 2;
    localparam int DIVIDEND_W = HEIGHT_W + FRAC_W;
    localparam int DIVISOR_W  = 32;
    localparam int CLIP_W     = LINE_W - 1;
    localparam int PROD_W     = CLIP_W + FIX_W;
    localparam int REGION_W   = 2;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 88;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [7:0]          ALPHA_FULL = 8'hFF;
    localparam logic [LINE_W-1:0]   LINE_MAX   = '1;
    localparam logic [FIX_W-1:0]    FIX_MAX    = '1;

    // Opcodes carried in s_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Region codes carried in m_tuser
    localparam logic [REGION_W-1:0] REGION_CEILING = 2'd0;
    localparam logic [REGION_W-1:0] REGION_WALL    = 2'd1;
    localparam logic [REGION_W-1:0] REGION_FLOOR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CEILING_RGB  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR_RGB    = 2'd2;

    typedef struct packed {
        logic load_col;    // capture a column-start transaction, start line division
        logic latch_line;  // take the line height from the divider
        logic geom;        // clip the wall, start step division
        logic latch_step;  // take the texture step from the divider
        logic mul;         // clipped rows times step
        logic load_pos;    // saturate start position, open the column
        logic pixel;       // produce one pixel into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic col_active;
        logic out_stall;
    } dp_status_t;

    typedef struct packed {
        logic [ROW_W-1:0]    column_x;
        logic [FIX_W-1:0]    wall_distance;
        logic [TIDX_W-1:0]   texture_index;
        logic [HEIGHT_W-1:0] texture_height;
        logic [ROW_W-1:0]    texture_column;
    } col_fields_t;

endpackage

@@ hdl/rwcr_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle
// when the quotient register holds the result.
// ----------------------------------------------------------------------------
module rwcr_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [rwcr_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [rwcr_pkg::DIVISOR_W-1:0]    divisor,
    output logic                              done,
    output logic [rwcr_pkg::DIVIDEND_W-1:0]   quotient
);

    import rwcr_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/rwcr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall column datapath
// Column geometry, texture step and position, per-row pixel generation and
// the output register.
// ----------------------------------------------------------------------------
module rwcr_datapath #(
    parameter int MAX_IMAGE_HEIGHT = 4096,
    parameter int TEXTURE_COUNT    = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rwcr_pkg::dp_cmd_t       cmd,
    output rwcr_pkg::dp_status_t    status,
    input  rwcr_pkg::col_fields_t   col_in,
    input  logic [rwcr_pkg::HEIGHT_W-1:0] image_height,
    input  logic [rwcr_pkg::RGB_W-1:0]    ceiling_rgb,
    input  logic [rwcr_pkg::RGB_W-1:0]    floor_rgb,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [rwcr_pkg::ROW_W-1:0]    pixel_row,
    output logic [rwcr_pkg::ROW_W-1:0]    pixel_column,
    output logic [rwcr_pkg::REGION_W-1:0] region,
    output logic [rwcr_pkg::FIX_W-1:0]    fill_rgba,
    output logic [rwcr_pkg::TIDX_W-1:0]   out_texture_index,
    output logic [rwcr_pkg::ROW_W-1:0]    out_texture_column,
    output logic [rwcr_pkg::ROW_W-1:0]    texture_row,
    output logic                    last_row
);

    import rwcr_pkg::*;

    localparam logic [HEIGHT_W-1:0] MAX_H = HEIGHT_W'(MAX_IMAGE_HEIGHT);
    localparam logic [TIDX_W-1:0]   MAX_TIDX = TIDX_W'(TEXTURE_COUNT - 1);

    // Effective height: zero acts as one, large values clamp to the maximum.
    logic [HEIGHT_W-1:0] h_eff;
    always_comb begin
        h_eff = image_height;
        if (h_eff == '0)
            h_eff = HEIGHT_W'(1);
        if (h_eff > MAX_H)
            h_eff = MAX_H;
    end

    // Column registers
    logic                  col_active_reg, col_active_next;
    logic [ROW_W-1:0]      row_reg;
    logic [HEIGHT_W-1:0]   hcol_reg;
    logic                  dist_zero_reg;
    logic [LINE_W-1:0]     line_reg;
    logic [ROW_W-1:0]      top_reg;
    logic [ROW_W-1:0]      bottom_reg;
    logic [CLIP_W-1:0]     clipped_reg;
    logic [FIX_W-1:0]      step_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [FIX_W-1:0]      pos_reg;
    logic [TIDX_W-1:0]     tidx_reg;
    logic [HEIGHT_W-1:0]   th_reg;
    logic [ROW_W-1:0]      tcol_reg;
    logic [ROW_W-1:0]      column_reg;

    // Shared divider: line height first, then texture step
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;

    assign div_start    = cmd.load_col | cmd.geom;
    assign div_dividend = cmd.load_col ? {h_eff, FRAC_W'(0)} : {th_reg, FRAC_W'(0)};
    assign div_divisor  = cmd.load_col ? col_in.wall_distance
                                       : DIVISOR_W'(line_reg);

    rwcr_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Geometry
    logic [ROW_W-1:0]    half_h;
    logic [CLIP_W-1:0]   half_line;
    logic [LINE_W-1:0]   bottom_sum;
    logic [ROW_W-1:0]    top_calc;
    logic [ROW_W-1:0]    bottom_calc;
    logic [CLIP_W-1:0]   clipped_calc;
    logic [LINE_W-1:0]   line_calc;
    logic [TIDX_W-1:0]   tidx_calc;

    assign half_h     = hcol_reg[HEIGHT_W-1:1];
    assign half_line  = line_reg[LINE_W-1:1];
    assign bottom_sum = {1'b0, half_line} + LINE_W'(half_h);

    always_comb begin
        if (CLIP_W'(half_h) >= half_line) begin
            top_calc     = half_h - half_line[ROW_W-1:0];
            clipped_calc = '0;
        end else begin
            top_calc     = '0;
            clipped_calc = half_line - CLIP_W'(half_h);
        end
        if (bottom_sum >= LINE_W'(hcol_reg))
            bottom_calc = ROW_W'(hcol_reg - 1'b1);
        else
            bottom_calc = bottom_sum[ROW_W-1:0];
    end

    always_comb begin
        if (dist_zero_reg || (div_quo[DIVIDEND_W-1:LINE_W] != '0))
            line_calc = LINE_MAX;
        else
            line_calc = div_quo[LINE_W-1:0];
    end

    always_comb begin
        tidx_calc = col_in.texture_index;
        if (int'(col_in.texture_index) >= TEXTURE_COUNT)
            tidx_calc = MAX_TIDX;
    end

    // Pixel generation
    logic [ROW_W-1:0]    tex_lim;
    logic [HEIGHT_W-1:0] th_m1;
    logic [FRAC_W-1:0]   ty;
    logic [ROW_W-1:0]    trow_calc;
    logic [FIX_W:0]      pos_sum;
    logic [FIX_W-1:0]    pos_adv;
    logic                is_last;
    logic                in_wall;
    logic                in_ceiling;

    assign th_m1   = th_reg - 1'b1;
    assign tex_lim = th_m1[HEIGHT_W-1] ? '1 : th_m1[ROW_W-1:0];
    assign ty      = pos_reg[FIX_W-1:FRAC_W];
    always_comb begin
        if (th_reg == '0)
            trow_calc = '0;
        else if (ty > FRAC_W'(tex_lim))
            trow_calc = tex_lim;
        else
            trow_calc = ty[ROW_W-1:0];
    end
    assign pos_sum    = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_adv    = pos_sum[FIX_W] ? FIX_MAX : pos_sum[FIX_W-1:0];
    assign is_last    = HEIGHT_W'(row_reg) >= (h_eff - 1'b1);
    assign in_ceiling = row_reg < top_reg;
    assign in_wall    = !in_ceiling && (row_reg <= bottom_reg);

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]    o_row_reg;
    logic [ROW_W-1:0]    o_col_reg;
    logic [REGION_W-1:0] o_region_reg;
    logic [FIX_W-1:0]    o_fill_reg;
    logic [TIDX_W-1:0]   o_tidx_reg;
    logic [ROW_W-1:0]    o_tcol_reg;
    logic [ROW_W-1:0]    o_trow_reg;
    logic                o_last_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.pixel)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_comb begin
        col_active_next = col_active_reg;
        if (cmd.load_col)
            col_active_next = 1'b0;
        else if (cmd.load_pos)
            col_active_next = 1'b1;
        else if (cmd.pixel && is_last)
            col_active_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_active_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            col_active_reg <= col_active_next;
            m_valid_reg    <= m_valid_next;
        end

        if (cmd.load_col) begin
            hcol_reg      <= h_eff;
            dist_zero_reg <= col_in.wall_distance == '0;
            tidx_reg      <= tidx_calc;
            th_reg        <= col_in.texture_height;
            tcol_reg      <= col_in.texture_column;
            column_reg    <= col_in.column_x;
        end
        if (cmd.latch_line)
            line_reg <= line_calc;
        if (cmd.geom) begin
            top_reg     <= top_calc;
            bottom_reg  <= bottom_calc;
            clipped_reg <= clipped_calc;
        end
        if (cmd.latch_step)
            step_reg <= (line_reg == '0) ? FIX_MAX : FIX_W'(div_quo);
        if (cmd.mul)
            prod_reg <= PROD_W'(clipped_reg) * PROD_W'(step_reg);
        if (cmd.load_pos) begin
            pos_reg <= (prod_reg[PROD_W-1:FIX_W] != '0) ? FIX_MAX : prod_reg[FIX_W-1:0];
            row_reg <= '0;
        end

        if (cmd.pixel) begin
            o_row_reg  <= row_reg;
            o_col_reg  <= column_reg;
            o_last_reg <= is_last;
            if (!is_last)
                row_reg <= row_reg + 1'b1;
            if (in_ceiling) begin
                o_region_reg <= REGION_CEILING;
                o_fill_reg   <= {ceiling_rgb, ALPHA_FULL};
                o_tidx_reg   <= '0;
                o_tcol_reg   <= '0;
                o_trow_reg   <= '0;
            end else if (in_wall) begin
                o_region_reg <= REGION_WALL;
                o_fill_reg   <= '0;
                o_tidx_reg   <= tidx_reg;
                o_tcol_reg   <= tcol_reg;
                o_trow_reg   <= trow_calc;
                pos_reg      <= pos_adv;
            end else begin
                o_region_reg <= REGION_FLOOR;
                o_fill_reg   <= {floor_rgb, ALPHA_FULL};
                o_tidx_reg   <= '0;
                o_tcol_reg   <= '0;
                o_trow_reg   <= '0;
            end
        end
    end

    assign status.div_done   = div_done;
    assign status.col_active = col_active_reg;
    assign status.out_stall  = m_valid_reg && !m_ready;

    assign m_valid            = m_valid_reg;
    assign pixel_row          = o_row_reg;
    assign pixel_column       = o_col_reg;
    assign region             = o_region_reg;
    assign fill_rgba          = o_fill_reg;
    assign out_texture_index  = o_tidx_reg;
    assign out_texture_column = o_tcol_reg;
    assign texture_row        = o_trow_reg;
    assign last_row           = o_last_reg;

endmodule

@@ hdl/rwcr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall column controller
// Sequences the column set-up (two divisions, clipping, start position) and
// issues one pixel command per accepted pixel tick while a column is open.
// ----------------------------------------------------------------------------
module rwcr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_opcode,
    output logic                  s_ready,
    input  rwcr_pkg::dp_status_t  status,
    output rwcr_pkg::dp_cmd_t     cmd
);

    import rwcr_pkg::*;

    typedef enum logic [2:0] {
        ST_READY,
        ST_DIV_LINE,
        ST_GEOM,
        ST_DIV_STEP,
        ST_MUL,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_READY) && !status.out_stall;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_READY: begin
                if (accept && s_opcode == OP_START) begin
                    cmd.load_col = 1'b1;
                    state_next   = ST_DIV_LINE;
                end else if (accept && status.col_active) begin
                    // A tick with no open column is consumed silently.
                    cmd.pixel = 1'b1;
                end
            end
            ST_DIV_LINE: begin
                if (status.div_done) begin
                    cmd.latch_line = 1'b1;
                    state_next     = ST_GEOM;
                end
            end
            ST_GEOM: begin
                cmd.geom   = 1'b1;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                if (status.div_done) begin
                    cmd.latch_step = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_pos = 1'b1;
                state_next   = ST_READY;
            end
            default: begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_READY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/raycast_wall_column_rasterizer.sv @@
`timescale 1ns / 1ps
// A pixel tick transaction appears on the m_ side in the cycle after acceptance.
// Throughput: pixel ticks stream at one per cycle while the output is taken.
// After a column-start transaction the next one is accepted only once the set-up is
// through: the shared one-bit-per-cycle divider runs twice, plus the line latch,
// clipping, step latch, multiply and load steps.
// Reset (aresetn low, synchronous) closes any column, empties the output register
// and sets image_height to 480 and both colours to black.
// ----------------------------------------------------------------------------
// Raycast wall column rasterizer
// Renders one screen column of a raycaster: ceiling, textured wall
// coordinates and floor, one pixel per tick.
// ----------------------------------------------------------------------------
module raycast_wall_column_rasterizer #(
    parameter int MAX_IMAGE_HEIGHT = 4096,
    parameter int TEXTURE_COUNT    = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // column_x[11:0], wall_distance[43:12], texture_index[45:44],
    // texture_height[58:46], texture_column[70:59], zero pad[71]
    input  logic [rwcr_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_row[11:0], pixel_column[23:12], fill_rgba[55:24],
    // out_texture_index[57:56], out_texture_column[69:58], texture_row[81:70],
    // zero pad[87:82]
    output logic [rwcr_pkg::M_TDATA_W-1:0]    m_tdata,
    // region[1:0]
    output logic [rwcr_pkg::REGION_W-1:0]     m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [rwcr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rwcr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import rwcr_pkg::*;

    // Configuration registers
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [RGB_W-1:0]    ceiling_rgb_reg;
    logic [RGB_W-1:0]    floor_rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_height_reg <= HEIGHT_W'(480);
            ceiling_rgb_reg  <= '0;
            floor_rgb_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_CEILING_RGB:  ceiling_rgb_reg  <= cfg_wdata[RGB_W-1:0];
                CFG_FLOOR_RGB:    floor_rgb_reg    <= cfg_wdata[RGB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    col_fields_t col_in;
    assign col_in.column_x       = s_tdata[11:0];
    assign col_in.wall_distance  = s_tdata[43:12];
    assign col_in.texture_index  = s_tdata[45:44];
    assign col_in.texture_height = s_tdata[58:46];
    assign col_in.texture_column = s_tdata[70:59];

    dp_cmd_t    cmd;
    dp_status_t status;

    logic [ROW_W-1:0]  pixel_row;
    logic [ROW_W-1:0]  pixel_column;
    logic [FIX_W-1:0]  fill_rgba;
    logic [TIDX_W-1:0] out_texture_index;
    logic [ROW_W-1:0]  out_texture_column;
    logic [ROW_W-1:0]  texture_row;

    rwcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_opcode (s_tuser),
        .s_ready  (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rwcr_datapath #(
        .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
        .TEXTURE_COUNT    (TEXTURE_COUNT)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .col_in             (col_in),
        .image_height       (image_height_reg),
        .ceiling_rgb        (ceiling_rgb_reg),
        .floor_rgb          (floor_rgb_reg),
        .m_valid            (m_tvalid),
        .m_ready            (m_tready),
        .pixel_row          (pixel_row),
        .pixel_column       (pixel_column),
        .region             (m_tuser),
        .fill_rgba          (fill_rgba),
        .out_texture_index  (out_texture_index),
        .out_texture_column (out_texture_column),
        .texture_row        (texture_row),
        .last_row           (m_tlast)
    );

    assign m_tdata = {6'b0, texture_row, out_texture_column, out_texture_index,
                      fill_rgba, pixel_column, pixel_row};

`ifndef SYNTHESIS
    // A stalled result blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the output register is stalled");

    // Column set-up holds off the input side for the cycle after a start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_START) |=> !s_tready)
        else $error("input accepted during column set-up");

    // A new result only follows an accepted pixel tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == OP_PIXEL))
        else $error("result without a pixel tick");

    // A wall pixel carries no fill colour, other regions carry no texture row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == REGION_WALL) ? (fill_rgba == '0) : (texture_row == '0)))
        else $error("region and payload disagree");
`endif

endmodule

@@ test/raycast_wall_column_rasterizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall column rasterizer regression
// Streams column-start and pixel-tick transactions into the rasterizer. Each
// accepted tick is run through an in-bench column model, and every pixel that
// comes out is compared field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module raycast_wall_column_rasterizer_test;

    import rwcr_pkg::*;

    localparam int MAX_ROWS      = 4096;
    localparam int TEXTURE_SLOTS = 4;
    // A column start keeps the block busy with no pixel out while it sets up the column.
    localparam int DRAIN_CYCLES  = 80;

    typedef struct {
        logic                opcode;
        logic [ROW_W-1:0]    column_x;
        logic [FIX_W-1:0]    wall_distance;
        logic [TIDX_W-1:0]   texture_index;
        logic [HEIGHT_W-1:0] texture_height;
        logic [ROW_W-1:0]    texture_column;
    } column_item_t;

    typedef struct {
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    column;
        logic [REGION_W-1:0] region;
        logic [FIX_W-1:0]    fill;
        logic [TIDX_W-1:0]   tex_index;
        logic [ROW_W-1:0]    tex_column;
        logic [ROW_W-1:0]    tex_row;
        logic                last;
    } pixel_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [REGION_W-1:0]    m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    raycast_wall_column_rasterizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Register copies
    logic [HEIGHT_W-1:0] cfg_height  = 13'd480;
    logic [RGB_W-1:0]    cfg_ceiling = '0;
    logic [RGB_W-1:0]    cfg_floor   = '0;

    // Column state of the model
    logic                col_open    = 1'b0;
    logic [ROW_W-1:0]    cur_row     = '0;
    logic [ROW_W-1:0]    wall_top    = '0;
    logic [ROW_W-1:0]    wall_bot    = '0;
    logic [FIX_W-1:0]    tex_step    = '0;
    logic [FIX_W-1:0]    tex_pos     = '0;
    logic [TIDX_W-1:0]   col_tidx    = '0;
    logic [HEIGHT_W-1:0] col_theight = 13'd1;
    logic [ROW_W-1:0]    col_tcol    = '0;
    logic [ROW_W-1:0]    col_x       = '0;

    column_item_t items_to_send[$];
    pixel_t       pixels_due[$];
    column_item_t offered_item;
    bit           offer_taken   = 1'b0;
    int unsigned  send_idle_pct = 31;
    int unsigned  recv_idle_pct = 31;
    int unsigned  hold_request  = 0;
    int unsigned  hold_left     = 0;
    int unsigned  items_queued  = 0;
    int unsigned  errors        = 0;

    function automatic logic [HEIGHT_W-1:0] visible_rows();
        logic [HEIGHT_W-1:0] h;
        h = cfg_height;
        if (h == '0) h = HEIGHT_W'(1);
        if (32'(h) > MAX_ROWS) h = HEIGHT_W'(MAX_ROWS);
        return h;
    endfunction

    task automatic rasterize_item(input column_item_t it);
        logic [HEIGHT_W-1:0] h;
        logic [63:0]         quot;
        logic [63:0]         prod;
        logic [LINE_W-1:0]   line_h;
        int                  top_raw;
        logic [31:0]         bottom;
        logic [31:0]         clipped;
        logic [31:0]         idx;
        logic [31:0]         ty;
        logic [31:0]         lim;
        logic [32:0]         sum;
        pixel_t              px;
        h = visible_rows();
        if (it.opcode == OP_START) begin
            if (it.wall_distance == 0) begin
                line_h = LINE_MAX;
            end else begin
                quot = (64'(h) << FRAC_W) / 64'(it.wall_distance);
                line_h = (quot > 64'(LINE_MAX)) ? LINE_MAX : quot[LINE_W-1:0];
            end
            top_raw = int'(h >> 1) - int'(line_h >> 1);
            if (top_raw < 0) begin
                wall_top = '0;
                clipped = 32'(-top_raw);
            end else begin
                wall_top = top_raw[ROW_W-1:0];
                clipped = 0;
            end
            bottom = 32'(line_h >> 1) + 32'(h >> 1);
            if (bottom >= 32'(h)) bottom = 32'(h) - 1;
            wall_bot = bottom[ROW_W-1:0];
            if (line_h == 0)
                tex_step = FIX_MAX;
            else
                tex_step = 32'((64'(it.texture_height) << FRAC_W) / 64'(line_h));
            prod = 64'(clipped) * 64'(tex_step);
            tex_pos = (prod > 64'(FIX_MAX)) ? FIX_MAX : prod[FIX_W-1:0];
            idx = 32'(it.texture_index);
            if (idx >= TEXTURE_SLOTS) idx = TEXTURE_SLOTS - 1;
            col_tidx    = idx[TIDX_W-1:0];
            col_theight = it.texture_height;
            col_tcol    = it.texture_column;
            col_x       = it.column_x;
            cur_row     = '0;
            col_open    = 1'b1;
        end else if (col_open) begin
            px.row        = cur_row;
            px.column     = col_x;
            px.fill       = '0;
            px.tex_index  = '0;
            px.tex_column = '0;
            px.tex_row    = '0;
            if (cur_row < wall_top) begin
                px.region = REGION_CEILING;
                px.fill   = {cfg_ceiling, ALPHA_FULL};
            end else if (cur_row <= wall_bot) begin
                px.region = REGION_WALL;
                ty = 32'(tex_pos >> FRAC_W);
                if (col_theight == 0) begin
                    ty = 0;
                end else begin
                    lim = 32'(col_theight) - 1;
                    if (lim > 4095) lim = 4095;
                    if (ty > lim) ty = lim;
                end
                px.tex_index  = col_tidx;
                px.tex_column = col_tcol;
                px.tex_row    = ty[ROW_W-1:0];
                sum = 33'(tex_pos) + 33'(tex_step);
                tex_pos = sum[32] ? FIX_MAX : sum[FIX_W-1:0];
            end else begin
                px.region = REGION_FLOOR;
                px.fill   = {cfg_floor, ALPHA_FULL};
            end
            px.last = (32'(cur_row) >= 32'(h) - 1);
            pixels_due.push_back(px);
            if (px.last)
                col_open = 1'b0;
            else
                cur_row = cur_row + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixels_due.size() == 0) begin
            $error("pixel transaction with none predicted: row 0x%0h", m_tdata[11:0]);
            errors++;
        end else begin
            want = pixels_due.pop_front();
            check_field("pixel_row", 32'(want.row), 32'(m_tdata[11:0]));
            check_field("pixel_column", 32'(want.column), 32'(m_tdata[23:12]));
            check_field("region", 32'(want.region), 32'(m_tuser));
            check_field("fill_rgba", want.fill, m_tdata[55:24]);
            check_field("out_texture_index", 32'(want.tex_index), 32'(m_tdata[57:56]));
            check_field("out_texture_column", 32'(want.tex_column), 32'(m_tdata[69:58]));
            check_field("texture_row", 32'(want.tex_row), 32'(m_tdata[81:70]));
            check_field("last_row", 32'(want.last), 32'(m_tlast));
        end
    endtask

    // Both handshakes are sampled here; pixels are checked before the
    // transaction taken at this edge is predicted, as its pixel comes later.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_pixel();
            if (s_tvalid && s_tready) rasterize_item(offered_item);
        end
        offer_taken = aresetn && s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || offer_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_item = items_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= offered_item.opcode;
                s_tdata  <= {1'b0, offered_item.texture_column,
                             offered_item.texture_height, offered_item.texture_index,
                             offered_item.wall_distance, offered_item.column_x};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left == 0 && hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_IMAGE_HEIGHT: cfg_height  = value[HEIGHT_W-1:0];
            CFG_CEILING_RGB:  cfg_ceiling = value;
            CFG_FLOOR_RGB:    cfg_floor   = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_item(input logic op, input logic [ROW_W-1:0] x,
                              input logic [FIX_W-1:0] distance,
                              input logic [TIDX_W-1:0] tidx,
                              input logic [HEIGHT_W-1:0] th, input logic [ROW_W-1:0] tcol);
        column_item_t it;
        it.opcode         = op;
        it.column_x       = x;
        it.wall_distance  = distance;
        it.texture_index  = tidx;
        it.texture_height = th;
        it.texture_column = tcol;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    task automatic queue_tick();
        queue_item(OP_PIXEL, ROW_W'($urandom()), FIX_W'($urandom()), TIDX_W'($urandom()),
                   HEIGHT_W'($urandom()), ROW_W'($urandom()));
    endtask

    function automatic logic [FIX_W-1:0] pick_distance();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 10) return FIX_MAX;
        if (pick < 20) return FIX_W'($urandom());
        if (pick < 30) return FIX_W'($urandom_range(1, 1023));
        // Mostly a line height between a quarter and four times the screen.
        return FIX_W'($urandom_range(32'h4000, 32'h40000));
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_tex_height();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) return HEIGHT_W'($urandom_range(0, 8191));
        if (pick < 18) return '0;
        return HEIGHT_W'($urandom_range(1, 64));
    endfunction

    // A column start and its ticks: usually the full column, sometimes cut
    // short by the next start, sometimes with stray ticks past its end.
    task automatic queue_column();
        int unsigned rows;
        int unsigned ticks;
        int unsigned pick;
        rows = 32'(visible_rows());
        if ($urandom_range(99) < 8) queue_tick();
        queue_item(OP_START, ROW_W'($urandom()), pick_distance(), TIDX_W'($urandom()),
                   pick_tex_height(), ROW_W'($urandom()));
        pick = $urandom_range(99);
        if (pick < 75)
            ticks = rows;
        else if (pick < 90)
            ticks = $urandom_range(1, rows);
        else
            ticks = rows + $urandom_range(1, 3);
        if (ticks > 64) ticks = $urandom_range(8, 64);
        repeat (ticks) queue_tick();
    endtask

    task automatic settle();
        int unsigned waited;
        while (items_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        waited = 0;
        while (pixels_due.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_start;
        int unsigned pick;
        logic [CFG_DATA_W-1:0] rows_value;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a tick with no column open, then a zero-distance column.
        queue_tick();
        queue_item(OP_START, 12'hFFF, '0, 2'd3, 13'd4096, 12'hFFF);
        repeat (4) queue_tick();
        settle();

        // Shrink the screen under the open column; the stray tick is dropped.
        write_reg(CFG_IMAGE_HEIGHT, 24'd6);
        repeat (3) queue_tick();
        settle();

        // Far wall: zero line height, saturated step, zero texture height.
        write_reg(CFG_CEILING_RGB, 24'hFFFFFF);
        write_reg(CFG_FLOOR_RGB, 24'h000000);
        queue_item(OP_START, '0, FIX_MAX, '0, '0, '0);
        repeat (6) queue_tick();
        settle();

        // Tallest screen with a very near wall, then cut it to one row.
        write_reg(CFG_IMAGE_HEIGHT, 24'd4096);
        queue_item(OP_START, 12'h5A5, 32'd1, 2'd2, 13'h1FFF, 12'hA5A);
        repeat (4) queue_tick();
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 24'd1);
        queue_tick();
        settle();

        items_queued = 0;
        for (phase = 0; items_queued < 400; phase++) begin
            case (phase)
                0: rows_value = 24'd1;
                1: rows_value = 24'd0;
                2: rows_value = 24'h1FFF;
                3: rows_value = 24'd4096;
                default: begin
                    pick = $urandom_range(99);
                    rows_value = (pick < 70) ? CFG_DATA_W'($urandom_range(2, 24))
                                             : CFG_DATA_W'($urandom_range(25, 64));
                end
            endcase
            write_reg(CFG_IMAGE_HEIGHT, rows_value);
            if (phase == 1) begin
                write_reg(CFG_CEILING_RGB, 24'h000000);
                write_reg(CFG_FLOOR_RGB, 24'hFFFFFF);
            end else begin
                write_reg(CFG_CEILING_RGB, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
                write_reg(CFG_FLOOR_RGB, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
            end
            send_idle_pct = (phase == 4) ? 0 : 31;
            recv_idle_pct = (phase == 4) ? 0 : 31;
            // Output held off long enough for the block to back up its input.
            if (phase == 5) hold_request = 300;
            phase_start = items_queued;
            while (items_queued - phase_start < 40) queue_column();
            settle();
        end

        if (pixels_due.size() != 0) begin
            $error("%0d predicted pixels never arrived", pixels_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
